// ===== design/tmpg_pkg.sv =====
// Shared constants, register codes and helper functions for the torus point generator.
package tmpg_pkg;

  // Field widths
  localparam int unsigned IndexW = 16;
  localparam int unsigned CoordW = 18;
  localparam int unsigned CfgW   = 16;

  // Register indexes on the configuration port (paddr[3:2])
  localparam logic [1:0] RegRingSteps   = 2'd0;
  localparam logic [1:0] RegTubeSteps   = 2'd1;
  localparam logic [1:0] RegMajorRadius = 2'd2;
  localparam logic [1:0] RegMinorRadius = 2'd3;

  // Register reset values
  localparam logic [CfgW-1:0] RingStepsRst   = 16'd20;
  localparam logic [CfgW-1:0] TubeStepsRst   = 16'd10;
  localparam logic [CfgW-1:0] MajorRadiusRst = 16'd512;
  localparam logic [CfgW-1:0] MinorRadiusRst = 16'd128;

  // Half pi in Q30 radians
  localparam longint unsigned HalfPiQ30 = 64'd1686629713;

  // Output range in Q9.8
  localparam longint signed OutMax = 64'sd131071;
  localparam longint signed OutMin = -64'sd131072;

  // One quarter-wave sine entry, Q1.15, from a Taylor series to x^13 in Q30
  function automatic logic [15:0] sine_entry(input int unsigned addr_bits,
                                             input int unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint signed   sum;
    begin
      x    = (longint'(k) * HalfPiQ30) >> addr_bits;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      term = ((term * x2) >> 30) / 6;   sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 20;  sum = sum + longint'(term);
      term = ((term * x2) >> 30) / 42;  sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 72;  sum = sum + longint'(term);
      term = ((term * x2) >> 30) / 110; sum = sum - longint'(term);
      term = ((term * x2) >> 30) / 156; sum = sum + longint'(term);
      if (sum < 0) begin
        sum = 0;
      end
      sine_entry = 16'((sum + 64'sd16384) >>> 15);
    end
  endfunction

  // Saturate a rounded product to signed Q9.8
  function automatic logic [CoordW-1:0] sat_coord(input logic signed [50:0] v);
    begin
      if (v > 51'(OutMax)) begin
        sat_coord = 18'h1FFFF;
      end else if (v < 51'(OutMin)) begin
        sat_coord = 18'h20000;
      end else begin
        sat_coord = v[CoordW-1:0];
      end
    end
  endfunction

endpackage

// ===== design/torus_mesh_point_generator.sv =====
// Torus surface point generator: phase divider, quarter-wave sine lookup, radius products.
//
//  channel  | dir | transaction contents
//  ---------+-----+-------------------------------------------------------------
//  s_axis   | in  | tdata[15:0] ring_index, [31:16] tube_index
//  m_axis   | out | tdata[17:0] x_coord, [35:18] y_coord, [53:36] z_coord, rest 0
//  apb      | in  | ring_steps @0x0, tube_steps @0x4, major_radius @0x8,
//           |     | minor_radius @0xC (16 bits each)
//
// One grid point enters per cycle while the output is not stalled; the restoring
// phase divider resolves one quotient bit per stage.
// Each stage holds its transaction until the next stage frees up, so bubbles close
// up and nothing is dropped or repeated under output stalls.
// Reset clears the valid bits and loads the register defaults; no clearing pass.
module torus_mesh_point_generator #(
  parameter int unsigned PHASE_BITS           = 16,
  parameter int unsigned SINE_TABLE_ADDR_BITS = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // ring_index, tube_index
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // x_coord, y_coord, z_coord, zero pad
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned P     = PHASE_BITS;
  localparam int unsigned A     = SINE_TABLE_ADDR_BITS;
  localparam int unsigned TabN  = 1 << A;
  localparam int unsigned TW    = A + 2;
  localparam int unsigned DivN  = tmpg_pkg::IndexW + P;
  localparam int unsigned NS    = DivN + 6;
  localparam int unsigned SAddr = DivN;
  localparam int unsigned SRom  = DivN + 1;
  localparam int unsigned SSign = DivN + 2;
  localparam int unsigned SM1   = DivN + 3;
  localparam int unsigned SM2   = DivN + 4;
  localparam int unsigned SOut  = DivN + 5;

  typedef logic [15:0] tab_t [TabN+1];

  function automatic tab_t build_tab();
    tab_t t;
    begin
      for (int unsigned k = 0; k <= TabN; k++) begin
        t[k] = tmpg_pkg::sine_entry(A, k);
      end
      build_tab = t;
    end
  endfunction

  localparam tab_t SineTab = build_tab();

  // ---------------- configuration registers ----------------
  logic [15:0] ring_steps_q, tube_steps_q, major_radius_q, minor_radius_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_steps_q   <= tmpg_pkg::RingStepsRst;
      tube_steps_q   <= tmpg_pkg::TubeStepsRst;
      major_radius_q <= tmpg_pkg::MajorRadiusRst;
      minor_radius_q <= tmpg_pkg::MinorRadiusRst;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        tmpg_pkg::RegRingSteps:   ring_steps_q   <= pwdata[15:0];
        tmpg_pkg::RegTubeSteps:   tube_steps_q   <= pwdata[15:0];
        tmpg_pkg::RegMajorRadius: major_radius_q <= pwdata[15:0];
        tmpg_pkg::RegMinorRadius: minor_radius_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (paddr[3:2])
      tmpg_pkg::RegRingSteps:   prdata = {16'd0, ring_steps_q};
      tmpg_pkg::RegTubeSteps:   prdata = {16'd0, tube_steps_q};
      tmpg_pkg::RegMajorRadius: prdata = {16'd0, major_radius_q};
      tmpg_pkg::RegMinorRadius: prdata = {16'd0, minor_radius_q};
      default:                  prdata = 32'd0;
    endcase
  end

  // ---------------- stage handshake ----------------
  logic [NS-1:0] vld_q;
  logic [NS-1:0] en;

  assign en[NS-1] = !vld_q[NS-1] || m_axis_tready;
  for (genvar k = 0; k < NS - 1; k++) begin : g_en
    assign en[k] = !vld_q[k] || en[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= s_axis_tvalid;
      end
      for (int unsigned k = 1; k < NS; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign s_axis_tready = en[0];

  // ---------------- restoring phase dividers, one bit per stage ----------------
  logic [15:0] rem_u_q [DivN];
  logic [15:0] rem_v_q [DivN];
  logic [15:0] num_u_q [DivN];
  logic [15:0] num_v_q [DivN];
  logic [P-1:0] quo_u_q [DivN];
  logic [P-1:0] quo_v_q [DivN];

  for (genvar d = 0; d < DivN; d++) begin : g_div
    logic [15:0]  rem_u_in, rem_v_in, num_u_in, num_v_in;
    logic [P-1:0] quo_u_in, quo_v_in;
    logic [16:0]  trial_u, trial_v;
    logic         ge_u, ge_v;

    if (d == 0) begin : g_first
      assign rem_u_in = '0;
      assign rem_v_in = '0;
      assign num_u_in = s_axis_tdata[15:0];
      assign num_v_in = s_axis_tdata[31:16];
      assign quo_u_in = '0;
      assign quo_v_in = '0;
    end else begin : g_rest
      assign rem_u_in = rem_u_q[d-1];
      assign rem_v_in = rem_v_q[d-1];
      assign num_u_in = num_u_q[d-1];
      assign num_v_in = num_v_q[d-1];
      assign quo_u_in = quo_u_q[d-1];
      assign quo_v_in = quo_v_q[d-1];
    end

    // shift in the next dividend bit, subtract when it fits
    assign trial_u = {rem_u_in, num_u_in[15]};
    assign trial_v = {rem_v_in, num_v_in[15]};
    assign ge_u    = trial_u >= {1'b0, ring_steps_q};
    assign ge_v    = trial_v >= {1'b0, tube_steps_q};

    always_ff @(posedge clk_i) begin
      if (en[d]) begin
        rem_u_q[d] <= ge_u ? 16'(trial_u - {1'b0, ring_steps_q}) : trial_u[15:0];
        rem_v_q[d] <= ge_v ? 16'(trial_v - {1'b0, tube_steps_q}) : trial_v[15:0];
        num_u_q[d] <= {num_u_in[14:0], 1'b0};
        num_v_q[d] <= {num_v_in[14:0], 1'b0};
        quo_u_q[d] <= {quo_u_in[P-2:0], ge_u};
        quo_v_q[d] <= {quo_v_in[P-2:0], ge_v};
      end
    end
  end

  // ---------------- table phase and addresses ----------------
  logic [P-1:0]  ph_u, ph_v;
  logic [TW-1:0] tp_u, tp_v, tc_u, tc_v;

  assign ph_u = (ring_steps_q == '0) ? '0 : quo_u_q[DivN-1];
  assign ph_v = (tube_steps_q == '0) ? '0 : quo_v_q[DivN-1];

  if (P >= TW) begin : g_ph_cut
    assign tp_u = ph_u[P-1 -: TW];
    assign tp_v = ph_v[P-1 -: TW];
  end else begin : g_ph_ext
    assign tp_u = {ph_u, {(TW-P){1'b0}}};
    assign tp_v = {ph_v, {(TW-P){1'b0}}};
  end

  // cosine is the sine a quarter turn ahead
  assign tc_u = tp_u + TW'(TabN);
  assign tc_v = tp_v + TW'(TabN);

  function automatic logic [A:0] quarter_addr(input logic [TW-1:0] t);
    begin
      quarter_addr = t[A] ? (A+1)'(TabN - {1'b0, t[A-1:0]}) : {1'b0, t[A-1:0]};
    end
  endfunction

  logic [A:0] a_su_q, a_cu_q, a_sv_q, a_cv_q;
  logic [3:0] neg_a_q;   // su, cu, sv, cv

  always_ff @(posedge clk_i) begin
    if (en[SAddr]) begin
      a_su_q  <= quarter_addr(tp_u);
      a_cu_q  <= quarter_addr(tc_u);
      a_sv_q  <= quarter_addr(tp_v);
      a_cv_q  <= quarter_addr(tc_v);
      neg_a_q <= {tc_v[A+1], tp_v[A+1], tc_u[A+1], tp_u[A+1]};
    end
  end

  // ---------------- table read, one lookup each for sin u, cos u, sin v, cos v ----------------
  logic [15:0] t_su_q, t_cu_q, t_sv_q, t_cv_q;
  logic [3:0]  neg_r_q;

  always_ff @(posedge clk_i) begin
    if (en[SRom]) begin
      t_su_q  <= SineTab[a_su_q];
      t_cu_q  <= SineTab[a_cu_q];
      t_sv_q  <= SineTab[a_sv_q];
      t_cv_q  <= SineTab[a_cv_q];
      neg_r_q <= neg_a_q;
    end
  end

  // ---------------- quadrant sign ----------------
  logic signed [16:0] su_q, cu_q, sv_q, cv_q;

  function automatic logic signed [16:0] apply_sign(input logic [15:0] v, input logic neg);
    begin
      apply_sign = neg ? -$signed({1'b0, v}) : $signed({1'b0, v});
    end
  endfunction

  always_ff @(posedge clk_i) begin
    if (en[SSign]) begin
      su_q <= apply_sign(t_su_q, neg_r_q[0]);
      cu_q <= apply_sign(t_cu_q, neg_r_q[1]);
      sv_q <= apply_sign(t_sv_q, neg_r_q[2]);
      cv_q <= apply_sign(t_cv_q, neg_r_q[3]);
    end
  end

  // ---------------- radius: rad = R*2^15 + r*cos v, z product ----------------
  logic signed [33:0] rad_q, zp_q, zp2_q;
  logic signed [16:0] cu1_q, su1_q;
  logic signed [33:0] r_cv, r_sv;

  assign r_cv = $signed({18'd0, minor_radius_q}) * 34'(cv_q);
  assign r_sv = $signed({18'd0, minor_radius_q}) * 34'(sv_q);

  always_ff @(posedge clk_i) begin
    if (en[SM1]) begin
      rad_q <= $signed({3'd0, major_radius_q, 15'd0}) + r_cv;
      zp_q  <= r_sv;
      cu1_q <= cu_q;
      su1_q <= su_q;
    end
  end

  // ---------------- rad times cos u and sin u ----------------
  logic signed [50:0] xp_q, yp_q;

  always_ff @(posedge clk_i) begin
    if (en[SM2]) begin
      xp_q  <= 51'(rad_q) * 51'(cu1_q);
      yp_q  <= 51'(rad_q) * 51'(su1_q);
      zp2_q <= zp_q;
    end
  end

  // ---------------- round half up and saturate ----------------
  logic signed [50:0] xr, yr, zr;
  logic [tmpg_pkg::CoordW-1:0] x_q, y_q, z_q;

  assign xr = (xp_q + (51'sd1 <<< 29)) >>> 30;
  assign yr = (yp_q + (51'sd1 <<< 29)) >>> 30;
  assign zr = (51'(zp2_q) + (51'sd1 <<< 14)) >>> 15;

  always_ff @(posedge clk_i) begin
    if (en[SOut]) begin
      x_q <= tmpg_pkg::sat_coord(xr);
      y_q <= tmpg_pkg::sat_coord(yr);
      z_q <= tmpg_pkg::sat_coord(zr);
    end
  end

  assign m_axis_tvalid = vld_q[SOut];
  assign m_axis_tdata  = {2'b00, z_q, y_q, x_q};

  // ---------------- assertions ----------------
  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((&vld_q) && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while pipeline full and output stalled");

  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_wr && paddr[3:2] == tmpg_pkg::RegRingSteps) |=> ring_steps_q == $past(pwdata[15:0]))
    else $error("ring_steps write lost");

  a_zero_tube: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && minor_radius_q == '0) |-> (z_q == '0))
    else $error("z nonzero with zero minor radius");

endmodule

// ===== verif/torus_mesh_point_generator_tb.sv =====
// Self-checking testbench for the torus surface point generator.
`timescale 1ns / 1ps

module torus_mesh_point_generator_tb;

  localparam int unsigned AddrBits = 10;
  localparam int unsigned TabN     = 1 << AddrBits;
  localparam int unsigned Latency  = 16 + 16 + 6;

  typedef struct packed {
    logic [tmpg_pkg::CoordW-1:0] z;
    logic [tmpg_pkg::CoordW-1:0] y;
    logic [tmpg_pkg::CoordW-1:0] x;
  } point_t;

  typedef struct {
    logic [15:0] ring;
    logic [15:0] tube;
    logic [15:0] major;
    logic [15:0] minor;
    bit          typed;
    point_t      pt;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // ring_index, tube_index
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;        // x_coord, y_coord, z_coord, zero pad
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  torus_mesh_point_generator dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #5 clk_i = ~clk_i;

  // Shadow of the block's registers and its sine table
  logic [15:0] ring_steps_q, tube_steps_q, major_q, minor_q;
  int unsigned sine_tab [TabN+1];
  point_t      expected_points [$];
  bit          failed = 1'b0;
  bit          quiet = 1'b0;
  bit          hold_off = 1'b0;

  // Quarter-wave table: Taylor series in Q30, rounded to Q1.15
  function automatic int unsigned taylor_sine(int unsigned k);
    longint unsigned ang, ang2, term;
    longint signed acc;
    ang  = (longint'(k) * 64'd1686629713) >> AddrBits;
    ang2 = (ang * ang) >> 30;
    term = ang;
    acc  = longint'(ang);
    for (int n = 1; n <= 6; n++) begin
      term = ((term * ang2) >> 30) / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) acc -= longint'(term);
      else acc += longint'(term);
    end
    if (acc < 0) acc = 0;
    return int'((acc + 16384) >> 15);
  endfunction

  function automatic longint signed wave(int unsigned t);
    int unsigned q, o, v;
    t = t % (4 * TabN);
    q = t / TabN;
    o = t % TabN;
    v = (q % 2 == 1) ? sine_tab[TabN - o] : sine_tab[o];
    return (q >= 2) ? -longint'(v) : longint'(v);
  endfunction

  function automatic int unsigned angle_of(logic [15:0] idx, logic [15:0] steps);
    longint unsigned ph;
    if (steps == 0) return 0;
    ph = ((longint'(idx) << 16) / steps) & 64'hFFFF;
    return int'(ph >> 4);
  endfunction

  function automatic logic [tmpg_pkg::CoordW-1:0] clamp_q98(longint signed v);
    if (v > tmpg_pkg::OutMax) v = tmpg_pkg::OutMax;
    if (v < tmpg_pkg::OutMin) v = tmpg_pkg::OutMin;
    return v[tmpg_pkg::CoordW-1:0];
  endfunction

  function automatic point_t torus_point(logic [15:0] ring, logic [15:0] tube);
    int unsigned tu, tv;
    longint signed rad;
    point_t p;
    tu  = angle_of(ring, ring_steps_q);
    tv  = angle_of(tube, tube_steps_q);
    rad = (longint'(major_q) << 15) + longint'(minor_q) * wave(tv + TabN);
    p.x = clamp_q98((rad * wave(tu + TabN) + (64'sd1 <<< 29)) >>> 30);
    p.y = clamp_q98((rad * wave(tu) + (64'sd1 <<< 29)) >>> 30);
    p.z = clamp_q98((longint'(minor_q) * wave(tv) + 64'sd16384) >>> 15);
    return p;
  endfunction

  // Two-phase register write
  task automatic reg_write(logic [1:0] idx, logic [15:0] val);
    @(negedge clk_i);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = {idx, 2'b00}; pwdata = {16'h0, val};
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      tmpg_pkg::RegRingSteps:   ring_steps_q = val;
      tmpg_pkg::RegTubeSteps:   tube_steps_q = val;
      tmpg_pkg::RegMajorRadius: major_q = val;
      default:                  minor_q = val;
    endcase
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic drain();
    while (expected_points.size() != 0) @(negedge clk_i);
    repeat (Latency) @(negedge clk_i);
  endtask

  task automatic set_all(logic [15:0] rs, logic [15:0] ts, logic [15:0] mj, logic [15:0] mn);
    drain();
    reg_write(tmpg_pkg::RegRingSteps, rs);
    reg_write(tmpg_pkg::RegTubeSteps, ts);
    reg_write(tmpg_pkg::RegMajorRadius, mj);
    reg_write(tmpg_pkg::RegMinorRadius, mn);
  endtask

  // One input transaction; called at a falling edge, returns at a falling edge
  task automatic send_point(logic [15:0] ring, logic [15:0] tube, bit typed, point_t pt);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {tube, ring};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_points.push_back(typed ? pt : torus_point(ring, tube));
    @(negedge clk_i);
  endtask

  task automatic random_points(int count, logic [15:0] rs, logic [15:0] ts);
    logic [15:0] r, t;
    for (int i = 0; i < count; i++) begin
      r = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2 * rs + 1));
      t = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2 * ts + 1));
      send_point(r, t, 1'b0, '0);
    end
    s_axis_tvalid = 1'b0;
  endtask

  // Directed points; zero radii, zero angles and a half turn give results known by hand
  dir_row_t dir_rows [] = '{
    '{16'd0,     16'd0,     16'd512,   16'd128,   1'b0, '0},
    '{16'd5,     16'd0,     16'd512,   16'd128,   1'b0, '0},
    '{16'd10,    16'd5,     16'd512,   16'd128,   1'b0, '0},
    '{16'd15,    16'd7,     16'd512,   16'd128,   1'b0, '0},
    '{16'd19,    16'd9,     16'd512,   16'd128,   1'b0, '0},
    '{16'd20,    16'd10,    16'd512,   16'd128,   1'b0, '0},
    '{16'd65535, 16'd65535, 16'd512,   16'd128,   1'b0, '0},
    '{16'd21,    16'd13,    16'd512,   16'd128,   1'b0, '0},
    '{16'd0,     16'd0,     16'd0,     16'd0,     1'b1, '0},
    '{16'd65535, 16'd65535, 16'd0,     16'd0,     1'b1, '0},
    '{16'd3,     16'd4,     16'd0,     16'd0,     1'b1, '0},
    '{16'd0,     16'd0,     16'd65535, 16'd65535, 1'b1,
      '{18'h00000, 18'h00000, 18'h1FFFE}},
    '{16'd10,    16'd0,     16'd65535, 16'd65535, 1'b1,
      '{18'h00000, 18'h00000, 18'h20002}},
    '{16'd7,     16'd3,     16'd65535, 16'd65535, 1'b0, '0},
    '{16'd0,     16'd0,     16'd65535, 16'd0,     1'b0, '0},
    '{16'd5,     16'd5,     16'd0,     16'd65535, 1'b0, '0}
  };

  // Sender and configuration sequence
  initial begin
    for (int k = 0; k <= TabN; k++) sine_tab[k] = taylor_sine(k);
    ring_steps_q = tmpg_pkg::RingStepsRst; tube_steps_q = tmpg_pkg::TubeStepsRst;
    major_q = tmpg_pkg::MajorRadiusRst; minor_q = tmpg_pkg::MinorRadiusRst;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].major != major_q || dir_rows[i].minor != minor_q) begin
        s_axis_tvalid = 1'b0;
        drain();
        reg_write(tmpg_pkg::RegMajorRadius, dir_rows[i].major);
        reg_write(tmpg_pkg::RegMinorRadius, dir_rows[i].minor);
      end
      send_point(dir_rows[i].ring, dir_rows[i].tube, dir_rows[i].typed, dir_rows[i].pt);
    end
    s_axis_tvalid = 1'b0;

    // Zero step counts, and the largest ones
    set_all(16'd0, 16'd65535, 16'd512, 16'd128);
    random_points(120, 16'd16, 16'd65535);
    set_all(16'd65535, 16'd0, 16'd300, 16'd250);
    random_points(120, 16'd65535, 16'd16);
    // Long receiver hold-off while the sender keeps offering
    set_all(16'd1, 16'd1, 16'd65535, 16'd65535);
    hold_off = 1'b1;
    random_points(150, 16'd1, 16'd1);
    set_all(16'd7, 16'd3, 16'd0, 16'd0);
    random_points(100, 16'd7, 16'd3);
    for (int ph = 0; ph < 4; ph++) begin
      set_all(16'($urandom_range(1, 400)), 16'($urandom_range(1, 400)),
              16'($urandom), 16'($urandom));
      random_points(100, ring_steps_q, tube_steps_q);
    end
    quiet = 1'b1;
    set_all(16'($urandom), 16'($urandom), 16'($urandom_range(0, 2048)),
            16'($urandom_range(0, 1024)));
    random_points(150, ring_steps_q, tube_steps_q);

    drain();
    if (!failed) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Receiver readiness: random stall bursts, one long hold-off
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        hold_off = 1'b0;
        m_axis_tready = 1'b0;
        repeat (300) @(negedge clk_i);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
    end
  end

  // Output checker
  always @(posedge clk_i) begin
    point_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[53:0];
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected point x=%h y=%h z=%h", $time, got.x, got.y, got.z);
        failed = 1'b1;
      end else begin
        want = expected_points.pop_front();
        if (got.x !== want.x) begin
          $display("%0t: x_coord expected %h actual %h", $time, want.x, got.x);
          failed = 1'b1;
        end
        if (got.y !== want.y) begin
          $display("%0t: y_coord expected %h actual %h", $time, want.y, got.y);
          failed = 1'b1;
        end
        if (got.z !== want.z) begin
          $display("%0t: z_coord expected %h actual %h", $time, want.z, got.z);
          failed = 1'b1;
        end
      end
    end
  end

  // Run limit
  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
